/* hdl/skl_pkg.sv */
// Shared constants, keyword chain tables and edge lookup for the shader keyword lexer.
// No dependencies; used by skl_if, skl_scan, skl_outq and the top level.
package skl_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF   = 8;
  localparam int LINE_BITS_DEF     = 16;
  localparam int QDEPTH            = 4;

  // token kinds
  localparam logic [3:0] K_END     = 4'd0;
  localparam logic [3:0] K_UNKNOWN = 4'd1;
  localparam logic [3:0] K_ID      = 4'd2;
  localparam logic [3:0] K_PREC    = 4'd3;
  localparam logic [3:0] K_TYPE    = 4'd4;
  localparam logic [3:0] K_SAMP    = 4'd5;
  localparam logic [3:0] K_SEM     = 4'd6;
  localparam logic [3:0] K_TEXUNIT = 4'd7;
  localparam logic [3:0] K_UNIF    = 4'd8;
  localparam logic [3:0] K_ATTR    = 4'd9;

  // scanner states; values from NODE_BASE up are keyword chain nodes
  localparam logic [7:0] S_START  = 8'd0;
  localparam logic [7:0] S_ID     = 8'd1;
  localparam logic [7:0] S_PREC   = 8'd2;
  localparam logic [7:0] S_TYPE   = 8'd3;
  localparam logic [7:0] S_SAMP   = 8'd4;
  localparam logic [7:0] S_SEM    = 8'd5;
  localparam logic [7:0] S_UNIF   = 8'd6;
  localparam logic [7:0] S_ATTR   = 8'd7;
  localparam logic [7:0] S_IN     = 8'd8;
  localparam logic [7:0] S_TEX1   = 8'd9;
  localparam logic [7:0] S_TEXEND = 8'd10;
  localparam logic [7:0] S_TEXU   = 8'd11;
  localparam logic [7:0] S_CSTART = 8'd12;
  localparam logic [7:0] S_CLINE  = 8'd13;
  localparam logic [7:0] S_CBLOCK = 8'd14;
  localparam logic [7:0] S_CSTAR  = 8'd15;
  localparam logic [7:0] N_I      = 8'd16;
  localparam logic [7:0] N_U      = 8'd17;
  localparam logic [7:0] N_V      = 8'd18;
  localparam logic [7:0] N_VP     = 8'd19;
  localparam logic [7:0] N_VT     = 8'd20;
  localparam logic [7:0] N_VB     = 8'd21;
  localparam logic [7:0] N_VBL    = 8'd22;
  localparam logic [7:0] N_SMPS   = 8'd23;
  localparam logic [7:0] N_SMPR   = 8'd24;
  localparam logic [7:0] N_VECV   = 8'd25;
  localparam logic [7:0] N_VEC    = 8'd26;
  localparam logic [7:0] N_VTC    = 8'd27;
  localparam int         NODE_BASE = 32;

  localparam int NCHAIN = 50;

  // chain text, right justified: last character in the low byte
  localparam logic [71:0] CH_TEXT [NCHAIN] = '{
    72'("mediump"), 72'("highp"), 72'("lowp"), 72'("float"),
    72'("i"), 72'("v"), 72'("V"), 72'("TEXUNIT"),
    72'("attribute"), 72'("u"), 72'("s"), 72'("/"),
    72'("P"), 72'("COLOR"), 72'("NORMAL"), 72'("T"), 72'("B"),
    72'("OSITION"), 72'("SIZE"),
    72'("EXCOORD"), 72'("ANGENT"),
    72'("0"), 72'("1"), 72'("2"), 72'("3"), 72'("4"), 72'("5"), 72'("6"), 72'("7"),
    72'("INORMAL"), 72'("LEND"),
    72'("WEIGHT"), 72'("INDICES"),
    72'("v"), 72'("s"), 72'("n"),
    72'("niform"), 72'("s"), 72'("int"), 72'("v"),
    72'("ec"),
    72'("2"), 72'("3"), 72'("4"),
    72'("ampler"),
    72'("1D"), 72'("2D"), 72'("3D"), 72'("CUBE"), 72'("Buffer")
  };

  localparam int CH_LEN [NCHAIN] = '{
    7, 5, 4, 5, 1, 1, 1, 7, 9, 1, 1, 1,
    1, 5, 6, 1, 1, 7, 4, 7, 6,
    1, 1, 1, 1, 1, 1, 1, 1,
    7, 4, 6, 7,
    1, 1, 1, 6, 1, 3, 1, 2,
    1, 1, 1, 6,
    2, 2, 2, 4, 6
  };

  localparam logic [7:0] CH_FROM [NCHAIN] = '{
    S_START, S_START, S_START, S_START, S_START, S_START, S_START, S_START,
    S_START, S_START, S_START, S_START,
    N_V, N_V, N_V, N_V, N_V, N_VP, N_VP, N_VT, N_VT,
    N_VTC, N_VTC, N_VTC, N_VTC, N_VTC, N_VTC, N_VTC, N_VTC,
    N_VB, N_VB, N_VBL, N_VBL,
    N_I, N_I, N_I, N_U, N_U, N_U, N_U, N_VECV,
    N_VEC, N_VEC, N_VEC, N_SMPS,
    N_SMPR, N_SMPR, N_SMPR, N_SMPR, N_SMPR
  };

  localparam logic [7:0] CH_TO [NCHAIN] = '{
    S_PREC, S_PREC, S_PREC, S_TYPE, N_I, N_VECV, N_V, S_TEXU,
    S_ATTR, N_U, N_SMPS, S_CSTART,
    N_VP, S_SEM, S_SEM, N_VT, N_VB, S_SEM, S_SEM, N_VTC, S_SEM,
    S_SEM, S_SEM, S_SEM, S_SEM, S_SEM, S_SEM, S_SEM, S_SEM,
    S_SEM, N_VBL, S_SEM, S_SEM,
    N_VECV, N_SMPS, S_IN, S_UNIF, N_SMPS, S_TYPE, N_VECV, N_VEC,
    S_TYPE, S_TYPE, S_TYPE, N_SMPR,
    S_SAMP, S_SAMP, S_SAMP, S_SAMP, S_SAMP
  };

  localparam logic [3:0] CH_SEM [NCHAIN] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd15, 4'd0, 4'd11,
    4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
    4'd12, 4'd0, 4'd13, 4'd14,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0
  };

  typedef struct packed {
    logic       hit;
    logic [7:0] next;
    logic [3:0] sem;
  } edge_t;

  function automatic logic [7:0] chain_char(int i, int k);
    logic [71:0] t;
    t = CH_TEXT[i];
    return t[(CH_LEN[i] - 1 - k) * 8 +: 8];
  endfunction

  // first matching chain wins; an inner node belongs to exactly one chain
  function automatic edge_t find_edge(logic [7:0] s, logic [7:0] c);
    edge_t e;
    int    first;
    int    m;
    int    si;
    e     = '0;
    first = NODE_BASE;
    si    = int'(s);
    for (int i = 0; i < NCHAIN; i++) begin
      m = -1;
      if (s == CH_FROM[i] && c == chain_char(i, 0)) begin
        m = 0;
      end else if (CH_LEN[i] > 1 && si >= first && si < first + CH_LEN[i] - 1) begin
        if (c == chain_char(i, si - first + 1)) m = si - first + 1;
      end
      if (!e.hit && m >= 0) begin
        e.hit = 1'b1;
        if (m + 1 == CH_LEN[i]) begin
          e.next = CH_TO[i];
          e.sem  = CH_SEM[i];
        end else begin
          e.next = 8'(first + m);
          e.sem  = 4'd0;
        end
      end
      first = first + CH_LEN[i] - 1;
    end
    return e;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

/* hdl/skl_if.sv */
// Stream interfaces for the shader keyword lexer: byte input and token output.
// Depends on skl_pkg for default widths.
interface skl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface skl_out_if #(
  parameter int POSITION_BITS = skl_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = skl_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = skl_pkg::LINE_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [POSITION_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0]   token_length;
  logic [LINE_BITS-1:0]     line_number;
  logic [3:0]               semantic_code;
  logic [6:0]               unit_number;
  logic                     last;
  modport source (output valid, output token_kind, output token_start, output token_length,
                  output line_number, output semantic_code, output unit_number,
                  output last, input ready);
  modport sink (input valid, input token_kind, input token_start, input token_length,
                input line_number, input semantic_code, input unit_number,
                input last, output ready);
endinterface

/* hdl/skl_scan.sv */
// Scanner core: DFA state, counters and up to two token records per byte.
// Depends on skl_pkg (state codes, kinds, chain lookup).
module skl_scan #(
  parameter int POSITION_BITS = skl_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = skl_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = skl_pkg::LINE_BITS_DEF,
  localparam int REC_W = 4 + POSITION_BITS + LENGTH_BITS + LINE_BITS + 4 + 7 + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       ch,
  output logic [1:0]       rec_n,
  output logic [REC_W-1:0] rec0,
  output logic [REC_W-1:0] rec1
);

  localparam logic [LENGTH_BITS-1:0] LEN_TOP  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;

  logic [7:0]               st_r, st_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] beg_r, beg_nxt;
  logic [LENGTH_BITS-1:0]   cnt_r, cnt_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [3:0]               sem_r, sem_nxt;
  logic [6:0]               unit_r, unit_nxt;

  always_comb begin
    logic          again;
    logic          ended;
    logic [3:0]    kind;
    logic          emit;
    logic [REC_W-1:0] rec;
    logic [3:0]    d;
    skl_pkg::edge_t e;
    st_nxt   = st_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    cnt_nxt  = cnt_r;
    line_nxt = line_r;
    sem_nxt  = sem_r;
    unit_nxt = unit_r;
    rec_n    = 2'd0;
    rec0     = '0;
    rec1     = '0;
    again    = 1'b1;
    ended    = 1'b0;
    emit     = 1'b0;
    kind     = skl_pkg::K_END;
    rec      = '0;
    e        = '0;
    d        = ch[3:0] - 4'd0;
    // delimiter rescans: at most three passes reach a resting state
    for (int g = 0; g < 4; g++) begin
      if (again) begin
        again = 1'b0;
        emit  = 1'b0;
        kind  = skl_pkg::K_END;
        e     = skl_pkg::find_edge(st_nxt, ch);
        case (st_nxt)
          skl_pkg::S_START: begin
            if (ch == 8'd0) begin
              beg_nxt = pos_nxt; cnt_nxt = '0;
              emit = 1'b1; kind = skl_pkg::K_END; ended = 1'b1;
            end else if (e.hit) begin
              beg_nxt = pos_nxt; cnt_nxt = LENGTH_BITS'(1); st_nxt = e.next;
            end else if (ch == 8'h0a) begin
              if (line_nxt != LINE_TOP) line_nxt = line_nxt + 1'b1;
            end else if (skl_pkg::is_letter(ch)) begin
              beg_nxt = pos_nxt; cnt_nxt = LENGTH_BITS'(1); st_nxt = skl_pkg::S_ID;
            end else if (ch != 8'h20 && ch != 8'h09 && ch != 8'h0d) begin
              beg_nxt = pos_nxt; cnt_nxt = LENGTH_BITS'(1);
              emit = 1'b1; kind = skl_pkg::K_UNKNOWN;
            end
          end
          skl_pkg::S_ID: begin
            if (skl_pkg::is_letter(ch) || skl_pkg::is_digit(ch)) begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
            end else begin
              emit = 1'b1; kind = skl_pkg::K_ID; st_nxt = skl_pkg::S_START; again = 1'b1;
            end
          end
          skl_pkg::S_PREC, skl_pkg::S_TYPE, skl_pkg::S_SAMP, skl_pkg::S_SEM,
          skl_pkg::S_UNIF, skl_pkg::S_ATTR, skl_pkg::S_TEXEND: begin
            if (skl_pkg::is_letter(ch) || skl_pkg::is_digit(ch)) begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
              st_nxt = skl_pkg::S_ID;
            end else begin
              emit = 1'b1;
              case (st_nxt)
                skl_pkg::S_PREC: kind = skl_pkg::K_PREC;
                skl_pkg::S_TYPE: kind = skl_pkg::K_TYPE;
                skl_pkg::S_SAMP: kind = skl_pkg::K_SAMP;
                skl_pkg::S_SEM:  kind = skl_pkg::K_SEM;
                skl_pkg::S_UNIF: kind = skl_pkg::K_UNIF;
                skl_pkg::S_ATTR: kind = skl_pkg::K_ATTR;
                default:         kind = skl_pkg::K_TEXUNIT;
              endcase
              st_nxt = skl_pkg::S_START; again = 1'b1;
            end
          end
          skl_pkg::S_IN: begin
            if (ch == "t") begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
              st_nxt = skl_pkg::S_TYPE;
            end else if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0a || ch == 8'h0d) begin
              emit = 1'b1; kind = skl_pkg::K_ATTR; st_nxt = skl_pkg::S_START; again = 1'b1;
            end else begin
              st_nxt = skl_pkg::S_ID; again = 1'b1;
            end
          end
          skl_pkg::S_TEXU: begin
            if (skl_pkg::is_digit(ch)) begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
              unit_nxt = {3'd0, d};
              st_nxt = (ch == "0") ? skl_pkg::S_TEXEND : skl_pkg::S_TEX1;
            end else begin
              st_nxt = skl_pkg::S_ID; again = 1'b1;
            end
          end
          skl_pkg::S_TEX1: begin
            if (skl_pkg::is_digit(ch)) begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
              unit_nxt = 7'(unit_nxt * 7'd10 + {3'd0, d});
              st_nxt = skl_pkg::S_TEXEND;
            end else if (skl_pkg::is_letter(ch)) begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
              st_nxt = skl_pkg::S_ID;
            end else begin
              emit = 1'b1; kind = skl_pkg::K_TEXUNIT; st_nxt = skl_pkg::S_START; again = 1'b1;
            end
          end
          skl_pkg::S_CSTART: begin
            if (ch == "/") begin
              cnt_nxt = '0; st_nxt = skl_pkg::S_CLINE;
            end else if (ch == "*") begin
              cnt_nxt = '0; st_nxt = skl_pkg::S_CBLOCK;
            end else begin
              emit = 1'b1; kind = skl_pkg::K_UNKNOWN; st_nxt = skl_pkg::S_START; again = 1'b1;
            end
          end
          skl_pkg::S_CLINE, skl_pkg::S_CBLOCK, skl_pkg::S_CSTAR: begin
            if (ch == 8'd0) begin
              beg_nxt = pos_nxt; cnt_nxt = '0;
              emit = 1'b1; kind = skl_pkg::K_END; ended = 1'b1;
            end else if (st_nxt == skl_pkg::S_CLINE) begin
              if (ch == 8'h0a) begin
                if (line_nxt != LINE_TOP) line_nxt = line_nxt + 1'b1;
                st_nxt = skl_pkg::S_START;
              end
            end else if (st_nxt == skl_pkg::S_CBLOCK) begin
              if (ch == "*") st_nxt = skl_pkg::S_CSTAR;
              else if (ch == 8'h0a && line_nxt != LINE_TOP) line_nxt = line_nxt + 1'b1;
            end else begin
              // a second star does not re-arm the close
              if (ch == "/") st_nxt = skl_pkg::S_START;
              else begin
                if (ch == 8'h0a && line_nxt != LINE_TOP) line_nxt = line_nxt + 1'b1;
                st_nxt = skl_pkg::S_CBLOCK;
              end
            end
          end
          default: begin
            if (e.hit) begin
              if (cnt_nxt != LEN_TOP) cnt_nxt = cnt_nxt + 1'b1;
              st_nxt = e.next;
              if (e.next == skl_pkg::S_SEM) sem_nxt = e.sem;
            end else begin
              st_nxt = skl_pkg::S_ID; again = 1'b1;
            end
          end
        endcase
        if (emit) begin
          rec = {kind, beg_nxt, cnt_nxt, line_nxt,
                 (kind == skl_pkg::K_SEM) ? sem_nxt : 4'd0,
                 (kind == skl_pkg::K_TEXUNIT) ? unit_nxt : 7'd0, 1'b0};
          if (rec_n == 2'd0) rec0 = rec;
          else rec1 = rec;
          rec_n = rec_n + 2'd1;
        end
      end
    end
    if (ended) begin
      st_nxt   = skl_pkg::S_START;
      pos_nxt  = '0;
      line_nxt = LINE_BITS'(1);
      cnt_nxt  = '0;
    end else begin
      pos_nxt = pos_nxt + 1'b1;
    end
    if (rec_n == 2'd1) rec0[0] = 1'b1;
    if (rec_n == 2'd2) rec1[0] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= skl_pkg::S_START;
      pos_r  <= '0;
      beg_r  <= '0;
      cnt_r  <= '0;
      line_r <= LINE_BITS'(1);
      sem_r  <= '0;
      unit_r <= '0;
    end else if (fire) begin
      st_r   <= st_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      cnt_r  <= cnt_nxt;
      line_r <= line_nxt;
      sem_r  <= sem_nxt;
      unit_r <= unit_nxt;
    end
  end

endmodule

/* hdl/skl_outq.sv */
// Result queue: takes zero, one or two token records per cycle, hands out one per beat.
// Depends on skl_pkg for the queue depth.
module skl_outq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [1:0]   push_n,
  input  logic [W-1:0] d0,
  input  logic [W-1:0] d1,
  output logic         room2,
  output logic         q_valid,
  input  logic         q_ready,
  output logic [W-1:0] q_data
);

  localparam int AW = $clog2(skl_pkg::QDEPTH);

  logic [W-1:0]  mem_r [skl_pkg::QDEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_in;

  assign n_in    = push ? push_n : 2'd0;
  assign pop     = q_valid && q_ready;
  assign q_valid = cnt_r != '0;
  assign q_data  = mem_r[rd_r];
  assign room2   = cnt_r <= (AW+1)'(skl_pkg::QDEPTH - 2);
  assign cnt_nxt = cnt_r + (AW+1)'(n_in) - (AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem_r[wr_r] <= d0;
    if (n_in == 2'd2) mem_r[wr_r + 1'b1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + AW'(n_in);
      rd_r  <= rd_r + AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/shader_keyword_lexer_core.sv */
// Top level of the shader keyword lexer: byte stream in, token stream out.
// Depends on skl_pkg, skl_if, skl_scan and skl_outq.
//
//  channel  | dir | beat payload
//  in_bus   | in  | ch: one source byte, 0 ends the source
//  out_bus  | out | token_kind, token_start, token_length, line_number,
//           |     | semantic_code, unit_number, last
//
// One byte is accepted per ready cycle; it and any rescan are resolved in the same cycle.
// A byte yields zero to two tokens, queued in a four-entry result queue, one per out beat.
// in_bus.ready drops while the queue has fewer than two free entries.
// Synchronous active-low reset: start state, offset 0, line 1, queue empty.
module shader_keyword_lexer_core #(
  parameter int POSITION_BITS = skl_pkg::POSITION_BITS_DEF,
  parameter int LENGTH_BITS   = skl_pkg::LENGTH_BITS_DEF,
  parameter int LINE_BITS     = skl_pkg::LINE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  skl_in_if.sink    in_bus,
  skl_out_if.source out_bus
);

  localparam int REC_W = 4 + POSITION_BITS + LENGTH_BITS + LINE_BITS + 4 + 7 + 1;

  logic             fire;
  logic [1:0]       rec_n;
  logic [REC_W-1:0] rec0, rec1, q_data;
  logic             room2;

  assign in_bus.ready = room2;
  assign fire         = in_bus.valid && room2;

  skl_scan #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .ch   (in_bus.ch),
    .rec_n(rec_n),
    .rec0 (rec0),
    .rec1 (rec1)
  );

  skl_outq #(.W(REC_W)) u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fire),
    .push_n (rec_n),
    .d0     (rec0),
    .d1     (rec1),
    .room2  (room2),
    .q_valid(out_bus.valid),
    .q_ready(out_bus.ready),
    .q_data (q_data)
  );

  assign {out_bus.token_kind, out_bus.token_start, out_bus.token_length,
          out_bus.line_number, out_bus.semantic_code, out_bus.unit_number,
          out_bus.last} = q_data;

endmodule
